// ===== sv/msp_pkg.sv =====
package msp_pkg;

    // Two-bit symbol codes.
    localparam logic [1:0] SYM_DIT   = 2'b10;
    localparam logic [1:0] SYM_DAH   = 2'b01;
    localparam logic [1:0] SYM_SPACE = 2'b11;
    localparam logic [1:0] SYM_EOC   = 2'b00;

    // Request opcodes.
    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    // Character codes that need special handling.
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    // Sizes of the symbol buffers.
    localparam int BYTE_SYMS = 4;
    localparam int PAT_W     = 15;
    localparam int CODE_W    = 32;
    localparam int BUF_W     = 40;
    localparam int NSYM_W    = 5;

    // One dot/dash pattern: length and pattern bits, dash = 1, last element in bit 0.
    typedef struct packed {
        logic [3:0]       len;
        logic [PAT_W-1:0] pat;
    } msp_code_t;

    // One classified request as it travels from front to back.
    typedef struct packed {
        logic              flush;
        logic [NSYM_W-1:0] nsym;
        logic [CODE_W-1:0] syms;
    } msp_entry_t;

    // Morse pattern of a lowercase character; unknown bytes give eight dits.
    function automatic msp_code_t code_lookup(logic [7:0] c);
        msp_code_t k;
        unique case (c)
            "a":   k = '{4'd2, 15'b01};
            "b":   k = '{4'd4, 15'b1000};
            "c":   k = '{4'd4, 15'b1010};
            "d":   k = '{4'd3, 15'b100};
            "e":   k = '{4'd1, 15'b0};
            "f":   k = '{4'd4, 15'b0010};
            "g":   k = '{4'd3, 15'b110};
            "h":   k = '{4'd4, 15'b0000};
            "i":   k = '{4'd2, 15'b00};
            "j":   k = '{4'd4, 15'b0111};
            "k":   k = '{4'd3, 15'b101};
            "l":   k = '{4'd4, 15'b0100};
            "m":   k = '{4'd2, 15'b11};
            "n":   k = '{4'd2, 15'b10};
            "o":   k = '{4'd3, 15'b111};
            "p":   k = '{4'd4, 15'b0110};
            "q":   k = '{4'd4, 15'b1101};
            "r":   k = '{4'd3, 15'b010};
            "s":   k = '{4'd3, 15'b000};
            "t":   k = '{4'd1, 15'b1};
            "u":   k = '{4'd3, 15'b001};
            "v":   k = '{4'd4, 15'b0001};
            "w":   k = '{4'd3, 15'b011};
            "x":   k = '{4'd4, 15'b1001};
            "y":   k = '{4'd4, 15'b1011};
            "z":   k = '{4'd4, 15'b1100};
            "&":   k = '{4'd5, 15'b01000};
            8'h27: k = '{4'd6, 15'b011110};
            "@":   k = '{4'd6, 15'b011010};
            "(":   k = '{4'd5, 15'b10110};
            ")":   k = '{4'd6, 15'b101101};
            ":":   k = '{4'd6, 15'b111000};
            ",":   k = '{4'd6, 15'b110011};
            "=":   k = '{4'd5, 15'b10001};
            "!":   k = '{4'd6, 15'b101011};
            ".":   k = '{4'd6, 15'b010101};
            "-":   k = '{4'd6, 15'b100001};
            "%":   k = '{4'd15, 15'b111111001011111};
            "+":   k = '{4'd5, 15'b01010};
            8'h22: k = '{4'd6, 15'b010010};
            "?":   k = '{4'd6, 15'b001100};
            "/":   k = '{4'd5, 15'b10010};
            8'h0A: k = '{4'd4, 15'b0101};
            "0":   k = '{4'd5, 15'b11111};
            "1":   k = '{4'd5, 15'b01111};
            "2":   k = '{4'd5, 15'b00111};
            "3":   k = '{4'd5, 15'b00011};
            "4":   k = '{4'd5, 15'b00001};
            "5":   k = '{4'd5, 15'b00000};
            "6":   k = '{4'd5, 15'b10000};
            "7":   k = '{4'd5, 15'b11000};
            "8":   k = '{4'd5, 15'b11100};
            "9":   k = '{4'd5, 15'b11110};
            default: k = '{4'd8, 15'b0};
        endcase
        return k;
    endfunction

    // Expand a pattern into left-aligned two-bit symbols; the slots after it
    // stay zero, which is the end-of-character mark.
    function automatic logic [CODE_W-1:0] code_symbols(msp_code_t k);
        logic [CODE_W-1:0] s;
        logic [3:0]        idx;
        s = '0;
        for (int i = 0; i < PAT_W; i++) begin
            idx = k.len - 4'(i) - 4'd1;
            if (4'(i) < k.len) begin
                s[CODE_W-1-2*i -: 2] = k.pat[idx] ? SYM_DAH : SYM_DIT;
            end
        end
        return s;
    endfunction

endpackage

// ===== sv/msp_in_if.sv =====
interface msp_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] char_code;

    modport source (output valid, output op, output char_code, input ready);
    modport sink (input valid, input op, input char_code, output ready);
endinterface

// ===== sv/msp_out_if.sv =====
interface msp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] packed_byte;
    logic       last_of_run;

    modport source (output valid, output packed_byte, output last_of_run, input ready);
    modport sink (input valid, input packed_byte, input last_of_run, output ready);
endinterface

// ===== sv/morse_symbol_packer_core.sv =====
// Channel        Role    Payload                      Handshake
// char_stream    sink    op, char_code                valid / ready
// byte_stream    source  packed_byte, last_of_run     valid / ready
//
// The back end sends one packed byte per cycle from its output register while
// byte_stream is ready; a request completes 0 to 4 bytes, and that single
// output register sets the sustained rate.
// rst_n clears the queue, the partial byte and the output register at once.
// A stall on byte_stream holds the back end while the front keeps taking
// requests until the QUEUE_DEPTH-entry queue fills.
module morse_symbol_packer_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    msp_in_if.sink     char_stream,
    msp_out_if.source  byte_stream
);

    logic                push, pop, full, head_valid;
    msp_pkg::msp_entry_t push_entry, head_entry;

    // Front end: handshake and character classification.
    msp_front u_front (
        .char_stream (char_stream),
        .full        (full),
        .push        (push),
        .entry       (push_entry)
    );

    // Queue between classification and packing.
    msp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    // Back end: symbol packing and byte output.
    msp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_entry  (head_entry),
        .pop         (pop),
        .byte_stream (byte_stream)
    );

endmodule

// ===== sv/msp_front.sv =====
module msp_front (
    msp_in_if.sink              char_stream,
    input  logic                full,
    output logic                push,
    output msp_pkg::msp_entry_t entry
);

    logic [7:0]         c_fold;
    msp_pkg::msp_code_t code;

    // Take a request whenever the queue has room.
    assign char_stream.ready = !full;
    assign push              = char_stream.valid && !full;

    // Fold uppercase letters and look up the pattern.
    always_comb
    begin
        if (char_stream.char_code >= msp_pkg::CHAR_UPPER_A &&
            char_stream.char_code <= msp_pkg::CHAR_UPPER_Z)
        begin
            c_fold = char_stream.char_code + msp_pkg::CASE_OFFSET;
        end
        else
        begin
            c_fold = char_stream.char_code;
        end
        code = msp_pkg::code_lookup(c_fold);
    end

    // Classify the request into a symbol run for the back end.
    always_comb
    begin
        if (char_stream.op == msp_pkg::OP_FLUSH)
        begin
            entry = '{flush: 1'b1, nsym: '0, syms: '0};
        end
        else if (c_fold == msp_pkg::CHAR_SPACE)
        begin
            entry = '{flush: 1'b0, nsym: 5'd1,
                      syms: {msp_pkg::SYM_SPACE, {(msp_pkg::CODE_W-2){1'b0}}}};
        end
        else
        begin
            entry = '{flush: 1'b0,
                      nsym: 5'(code.len) + 5'd1,
                      syms: msp_pkg::code_symbols(code)};
        end
    end

endmodule

// ===== sv/msp_queue.sv =====
module msp_queue #(
    parameter int DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  msp_pkg::msp_entry_t push_entry,
    input  logic                pop,
    output logic                full,
    output logic                head_valid,
    output msp_pkg::msp_entry_t head_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    msp_pkg::msp_entry_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== sv/msp_back.sv =====
module msp_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  msp_pkg::msp_entry_t head_entry,
    output logic                pop,
    msp_out_if.source           byte_stream
);

    localparam int BUF_W  = msp_pkg::BUF_W;
    localparam int NSYM_W = msp_pkg::NSYM_W;

    logic [7:0]        partial_reg, partial_next;
    logic [1:0]        slot_reg, slot_next;
    logic              busy_reg, busy_next;
    logic [BUF_W-1:0]  buf_reg, buf_next;
    logic [NSYM_W-1:0] cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_byte_reg, out_byte_next;
    logic              out_last_reg, out_last_next;

    logic [NSYM_W-1:0] head_nsym;
    logic [BUF_W-1:0]  load_buf, cur_buf, rem_buf, fin_buf;
    logic [NSYM_W-1:0] load_cnt, cur_cnt, rem_cnt, fin_cnt;
    logic              cur_valid, slot_free, has_byte, step, done;

    // A flush pads with end marks past two of them up to the byte boundary.
    always_comb
    begin
        if (head_entry.flush)
        begin
            unique case (slot_reg)
                2'd0:    head_nsym = 5'd4;
                2'd1:    head_nsym = 5'd3;
                2'd2:    head_nsym = 5'd2;
                default: head_nsym = 5'd5;
            endcase
        end
        else
        begin
            head_nsym = head_entry.nsym;
        end
    end

    // Join the partial byte with the new run of symbols.
    assign load_buf = {partial_reg, {(BUF_W-8){1'b0}}}
                    | ({head_entry.syms, 8'b0} >> {slot_reg, 1'b0});
    assign load_cnt = NSYM_W'(slot_reg) + head_nsym;

    assign cur_valid = busy_reg || head_valid;
    assign cur_buf   = busy_reg ? buf_reg : load_buf;
    assign cur_cnt   = busy_reg ? cnt_reg : load_cnt;
    assign slot_free = !out_valid_reg || byte_stream.ready;
    assign has_byte  = (cur_cnt >= NSYM_W'(msp_pkg::BYTE_SYMS));
    assign rem_buf   = cur_buf << 8;
    assign rem_cnt   = cur_cnt - NSYM_W'(msp_pkg::BYTE_SYMS);
    assign fin_buf   = has_byte ? rem_buf : cur_buf;
    assign fin_cnt   = has_byte ? rem_cnt : cur_cnt;

    // A step sends at most one byte; a byteless run ends at its first step.
    assign step = cur_valid && (!has_byte || slot_free);
    assign done = step && (!has_byte || (rem_cnt < NSYM_W'(msp_pkg::BYTE_SYMS)));
    assign pop  = step && !busy_reg;

    // Next state of the packer and the output register.
    always_comb
    begin
        partial_next   = partial_reg;
        slot_next      = slot_reg;
        busy_next      = busy_reg;
        buf_next       = buf_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !byte_stream.ready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (step && has_byte)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = cur_buf[BUF_W-1 -: 8];
            out_last_next  = done;
            buf_next       = rem_buf;
            cnt_next       = rem_cnt;
        end
        if (step)
        begin
            busy_next = !done;
        end
        if (done)
        begin
            partial_next = fin_buf[BUF_W-1 -: 8];
            slot_next    = fin_cnt[1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg   <= '0;
            slot_reg      <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            partial_reg   <= partial_next;
            slot_reg      <= slot_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        buf_reg      <= buf_next;
        cnt_reg      <= cnt_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign byte_stream.valid       = out_valid_reg;
    assign byte_stream.packed_byte = out_byte_reg;
    assign byte_stream.last_of_run = out_last_reg;

endmodule

// ===== sv/msp_checker.sv =====
module msp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       out_last
);

    // A stalled byte holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("output byte changed while stalled");

    // A byte that is not the last of its run is followed at once by the next.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_last |=> out_valid)
    else $error("gap inside a run of output bytes");

    // Nothing is shown right after reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !out_valid)
    else $error("output valid right after reset");

    // The queue is empty after reset, so requests are taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> in_ready)
    else $error("input not ready right after reset");

endmodule

bind morse_symbol_packer_core msp_checker u_msp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (char_stream.ready),
    .out_valid (byte_stream.valid),
    .out_ready (byte_stream.ready),
    .out_byte  (byte_stream.packed_byte),
    .out_last  (byte_stream.last_of_run)
);
